/* sv/laser_scan_occupancy_grid_update_top_defines.svh */
// Assertion macros for the file that checks its own logic.
`ifndef LASER_SCAN_OCCUPANCY_GRID_UPDATE_TOP_DEFINES_SVH
`define LASER_SCAN_OCCUPANCY_GRID_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define LSOG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsog assertion failed");

`define LSOG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsog assertion failed");

`else

`define LSOG_ASSERT_IMP(lbl, ante, cons)

`define LSOG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* sv/lsog_pkg.sv */
package lsog_pkg;

    localparam int GRID_SIDE = 256;
    localparam int SINE_TABLE_SIZE = 1024;

    localparam int GRID_W = $clog2(GRID_SIDE);
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(GRID_CELLS);

    localparam int CELL_W = 2;
    localparam logic [CELL_W-1:0] CELL_FREE = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OCC = 2'd1;
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 2'd2;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_BEAM = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_ABOVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIPPED_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd6;

    localparam int ANG_W = 16;
    localparam int IDX_W = 12;
    localparam int RANGE_W = 16;
    localparam int COL_W = 8;
    localparam int SIZE_W = 10;
    localparam int MARGIN_W = 3;
    localparam int SINE_W = 16;
    localparam int TI_W = $clog2(SINE_TABLE_SIZE);

    localparam int PROD_W = RANGE_W + 1 + SINE_W;
    localparam int HALF_W = $clog2(GRID_SIDE + 1) + SIZE_W + 14;
    localparam int NUM_W = ((PROD_W > HALF_W + 1) ? PROD_W : HALF_W + 1) + 1;
    localparam int DEN_W = SIZE_W + 15;
    localparam int COORD_W = NUM_W - 15 + 2;
    localparam int ERR_W = COORD_W + 2;
    localparam int RAY_STOP_CELLS = 2;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518853;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_TABLE_SIZE];

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } grid_wr_t;

    localparam coord_t CENTER = COORD_W'(GRID_SIDE / 2);

    function automatic logic [63:0] quarter_sine(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x = (k * TWO_PI_Q30) / 64'(SINE_TABLE_SIZE);
        x2 = (x * x) >> 30;
        t = ONE_Q30 - x2 / 64'd110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s;
    endfunction

    function automatic sine_lut_t build_sine();
        sine_lut_t   lut;
        logic [63:0] j;
        logic [63:0] v;
        for (int i = 0; i < SINE_TABLE_SIZE; i++)
        begin
            j = 64'(i % (SINE_TABLE_SIZE / 2));
            if (j > 64'(SINE_TABLE_SIZE / 4))
            begin
                j = 64'(SINE_TABLE_SIZE / 2) - j;
            end
            v = quarter_sine(j);
            if (i >= SINE_TABLE_SIZE / 2)
            begin
                lut[i] = SINE_W'(-v);
            end
            else
            begin
                lut[i] = SINE_W'(v);
            end
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine();

    function automatic logic on_grid(input coord_t x, input coord_t y);
        return (x >= 0) && (x < COORD_W'(GRID_SIDE)) && (y >= 0) && (y < COORD_W'(GRID_SIDE));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y);
        return ADDR_W'(y[GRID_W-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(x[GRID_W-1:0]);
    endfunction

endpackage

/* sv/laser_scan_occupancy_grid_update_top.sv */
// Read item: the cell is read in S_READ, taken in S_RDATA and loaded out from S_FINISH.
// Clear item: 65536 cells set to unknown, one per cycle. Beam item: setup, bit-serial end-cell
// division, then one ray cell per cycle, then the (2*margin_cells+1)^2 margin cells.
// Throughput is one item at a time; a result waits in the output register while the next item runs.
// After reset the control and config registers take reset values and the grid memory is swept
// to unknown cell by cell, during which no transaction is accepted on the input side.
`include "laser_scan_occupancy_grid_update_top_defines.svh"

module laser_scan_occupancy_grid_update_top
    import lsog_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // beam_index, range_mm, cell_col, cell_row, zero fill
    input  logic [47:0]           s_tdata,
    // opcode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_state, zero fill
    output logic [7:0]            m_tdata,
    // beam_skipped
    output logic [0:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_CLEAR = 4'd1;
    localparam logic [ST_W-1:0] S_BEAM0 = 4'd2;
    localparam logic [ST_W-1:0] S_BEAM1 = 4'd3;
    localparam logic [ST_W-1:0] S_BEAM2 = 4'd4;
    localparam logic [ST_W-1:0] S_BEAM3 = 4'd5;
    localparam logic [ST_W-1:0] S_DIV = 4'd6;
    localparam logic [ST_W-1:0] S_RINIT = 4'd7;
    localparam logic [ST_W-1:0] S_RAY = 4'd8;
    localparam logic [ST_W-1:0] S_MARGIN = 4'd9;
    localparam logic [ST_W-1:0] S_READ = 4'd10;
    localparam logic [ST_W-1:0] S_RDATA = 4'd11;
    localparam logic [ST_W-1:0] S_FINISH = 4'd12;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    logic [ANG_W-1:0]    start_angle_reg;
    logic [ANG_W-1:0]    angle_step_reg;
    logic [RANGE_W-1:0]  min_range_reg;
    logic [RANGE_W-1:0]  clip_above_reg;
    logic [RANGE_W-1:0]  clipped_range_reg;
    logic [SIZE_W-1:0]   cell_size_reg;
    logic [MARGIN_W-1:0] margin_reg;

    logic              clr_emit_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              out_valid_reg;
    logic              pend_valid_reg;

    logic [IDX_W-1:0]   beam_index_reg;
    logic [RANGE_W-1:0] range_reg;
    coord_t             col_reg;
    coord_t             row_reg;
    logic               rd_ok_reg;
    logic [CELL_W-1:0]  res_cell_reg;
    logic               res_skip_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic               out_skip_reg;

    logic [ANG_W-1:0]         ang_reg;
    logic [RANGE_W-1:0]       r_reg;
    logic signed [SINE_W-1:0] sin_reg;
    logic signed [SINE_W-1:0] cos_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [HALF_W-1:0]        half_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic signed [PROD_W-1:0] prod_s_reg;
    coord_t                   gx_reg;
    coord_t                   gy_reg;
    coord_t                   x0_reg;
    coord_t                   y0_reg;
    logic signed [ERR_W-1:0]  dx_reg;
    logic signed [ERR_W-1:0]  dy_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     sx_reg;
    logic                     sy_reg;
    logic signed [3:0]        ox_reg;
    logic signed [3:0]        oy_reg;
    logic [ADDR_W-1:0]        pend_addr_reg;

    logic                     in_accept;
    logic                     out_load;
    grid_wr_t                 mem_wr;
    logic                     mem_rd_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic [CELL_W-1:0]        mem_rd_data;

    logic                     div_start;
    logic signed [NUM_W-1:0]  num_x;
    logic signed [NUM_W-1:0]  num_y;
    logic                     div_x_done;
    logic                     div_y_done;
    coord_t                   quo_x;
    coord_t                   quo_y;

    logic [IDX_W+ANG_W-1:0]   ang_prod;
    logic [ANG_W+TI_W-1:0]    ti_prod;
    logic [TI_W-1:0]          ti;
    logic [TI_W:0]            ci_sum;
    logic [TI_W-1:0]          ci;
    logic [SIZE_W-1:0]        w_eff;

    coord_t                   gdx;
    coord_t                   gdy;
    coord_t                   adx;
    coord_t                   ady;
    coord_t                   rdx;
    coord_t                   rdy;
    coord_t                   ardx;
    coord_t                   ardy;
    logic                     ray_stop;
    logic                     ray_on;
    logic signed [ERR_W:0]    e2;
    logic                     step_x;
    logic                     step_y;
    logic signed [ERR_W-1:0]  err_step;
    coord_t                   mx;
    coord_t                   my;
    logic signed [3:0]        m_s;
    logic                     margin_last;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'b0, out_cell_reg};
    assign m_tuser = out_skip_reg;

    assign ang_prod = IDX_W'(beam_index_reg) * angle_step_reg;
    assign ti_prod = (ANG_W + TI_W)'(ang_reg) * (ANG_W + TI_W)'(SINE_TABLE_SIZE);
    assign ti = ti_prod[ANG_W+TI_W-1:ANG_W];
    assign ci_sum = (TI_W + 1)'(ti) + (TI_W + 1)'(SINE_TABLE_SIZE / 4);
    assign ci = (ci_sum >= (TI_W + 1)'(SINE_TABLE_SIZE)) ?
                TI_W'(ci_sum - (TI_W + 1)'(SINE_TABLE_SIZE)) : ci_sum[TI_W-1:0];
    assign w_eff = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;

    assign num_x = NUM_W'(prod_c_reg) + NUM_W'(half_reg);
    assign num_y = NUM_W'(prod_s_reg) + NUM_W'(half_reg);
    assign div_start = (state_reg == S_BEAM3);

    assign gdx = gx_reg - CENTER;
    assign gdy = gy_reg - CENTER;
    assign adx = gdx[COORD_W-1] ? -gdx : gdx;
    assign ady = gdy[COORD_W-1] ? -gdy : gdy;

    assign rdx = x0_reg - gx_reg;
    assign rdy = y0_reg - gy_reg;
    assign ardx = rdx[COORD_W-1] ? -rdx : rdx;
    assign ardy = rdy[COORD_W-1] ? -rdy : rdy;
    assign ray_stop = !((ardx > COORD_W'(RAY_STOP_CELLS)) || (ardy > COORD_W'(RAY_STOP_CELLS)));
    assign ray_on = on_grid(x0_reg, y0_reg);
    assign e2 = {err_reg, 1'b0};
    assign step_x = e2 > -(ERR_W + 1)'(dy_reg);
    assign step_y = e2 < (ERR_W + 1)'(dx_reg);
    assign err_step = err_reg - (step_x ? dy_reg : ERR_W'(0)) + (step_y ? dx_reg : ERR_W'(0));

    assign m_s = signed'({1'b0, margin_reg});
    assign mx = gx_reg + COORD_W'(ox_reg);
    assign my = gy_reg + COORD_W'(oy_reg);
    assign margin_last = (ox_reg == m_s) && (oy_reg == m_s);

    always_comb
    begin
        mem_wr = '0;
        mem_rd_en = 1'b0;
        mem_rd_addr = cell_addr(x0_reg, y0_reg);
        if (state_reg == S_CLEAR)
        begin
            mem_wr.en = 1'b1;
            mem_wr.addr = clr_addr_reg;
            mem_wr.data = CELL_UNKNOWN;
        end
        else if (state_reg == S_MARGIN)
        begin
            mem_wr.en = on_grid(mx, my);
            mem_wr.addr = cell_addr(mx, my);
            mem_wr.data = CELL_OCC;
        end
        else if (pend_valid_reg)
        begin
            mem_wr.en = (mem_rd_data != CELL_OCC);
            mem_wr.addr = pend_addr_reg;
            mem_wr.data = CELL_FREE;
        end
        if (state_reg == S_RAY)
        begin
            mem_rd_en = !ray_stop && ray_on;
        end
        else if (state_reg == S_READ)
        begin
            mem_rd_en = rd_ok_reg;
            mem_rd_addr = cell_addr(col_reg, row_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (s_tuser)
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_BEAM:  state_next = S_BEAM0;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(GRID_CELLS - 1))
                begin
                    state_next = clr_emit_reg ? S_FINISH : S_IDLE;
                end
            end
            S_BEAM0:
            begin
                state_next = (range_reg < min_range_reg) ? S_FINISH : S_BEAM1;
            end
            S_BEAM1: state_next = S_BEAM2;
            S_BEAM2: state_next = S_BEAM3;
            S_BEAM3: state_next = S_DIV;
            S_DIV:
            begin
                if (div_x_done)
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT: state_next = S_RAY;
            S_RAY:
            begin
                if (ray_stop)
                begin
                    state_next = S_MARGIN;
                end
            end
            S_MARGIN:
            begin
                if (margin_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:  state_next = S_RDATA;
            S_RDATA: state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_emit_reg <= 1'b0;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            start_angle_reg <= 16'd0;
            angle_step_reg <= 16'd64;
            min_range_reg <= 16'd0;
            clip_above_reg <= 16'd10000;
            clipped_range_reg <= 16'd10500;
            cell_size_reg <= 10'd100;
            margin_reg <= 3'd2;
        end
        else
        begin
            state_reg <= state_next;
            pend_valid_reg <= (state_reg == S_RAY) && !ray_stop && ray_on;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_accept)
            begin
                clr_emit_reg <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_ANGLE:   start_angle_reg <= cfg_wdata;
                    REG_ANGLE_STEP:    angle_step_reg <= cfg_wdata;
                    REG_MIN_RANGE:     min_range_reg <= cfg_wdata;
                    REG_CLIP_ABOVE:    clip_above_reg <= cfg_wdata;
                    REG_CLIPPED_RANGE: clipped_range_reg <= cfg_wdata;
                    REG_CELL_SIZE:     cell_size_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_MARGIN:        margin_reg <= cfg_wdata[MARGIN_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cell_reg <= res_cell_reg;
            out_skip_reg <= res_skip_reg;
        end
        if (pend_valid_reg || (state_reg == S_RAY))
        begin
            pend_addr_reg <= cell_addr(x0_reg, y0_reg);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    beam_index_reg <= s_tdata[11:0];
                    range_reg <= s_tdata[27:12];
                    col_reg <= COORD_W'(s_tdata[35:28]);
                    row_reg <= COORD_W'(s_tdata[43:36]);
                    rd_ok_reg <= on_grid(COORD_W'(s_tdata[35:28]), COORD_W'(s_tdata[43:36]));
                    res_cell_reg <= CELL_FREE;
                    res_skip_reg <= 1'b0;
                end
            end
            S_BEAM0:
            begin
                ang_reg <= start_angle_reg + ang_prod[ANG_W-1:0];
                r_reg <= (range_reg > clip_above_reg) ? clipped_range_reg : range_reg;
                res_skip_reg <= (range_reg < min_range_reg);
            end
            S_BEAM1:
            begin
                sin_reg <= SINE_LUT[ti];
                cos_reg <= SINE_LUT[ci];
                den_reg <= {w_eff, 15'd0};
                half_reg <= (HALF_W'(GRID_SIDE) * HALF_W'(w_eff)) << 14;
            end
            S_BEAM2:
            begin
                prod_c_reg <= signed'({1'b0, r_reg}) * cos_reg;
                prod_s_reg <= signed'({1'b0, r_reg}) * sin_reg;
            end
            S_DIV:
            begin
                if (div_x_done)
                begin
                    gx_reg <= quo_x;
                    gy_reg <= quo_y;
                end
            end
            S_RINIT:
            begin
                x0_reg <= CENTER;
                y0_reg <= CENTER;
                dx_reg <= ERR_W'(adx);
                dy_reg <= ERR_W'(ady);
                err_reg <= ERR_W'(adx) - ERR_W'(ady);
                sx_reg <= (CENTER < gx_reg);
                sy_reg <= (CENTER < gy_reg);
                ox_reg <= -m_s;
                oy_reg <= -m_s;
            end
            S_RAY:
            begin
                if (!ray_stop)
                begin
                    err_reg <= err_step;
                    if (step_x)
                    begin
                        x0_reg <= sx_reg ? x0_reg + COORD_W'(1) : x0_reg - COORD_W'(1);
                    end
                    if (step_y)
                    begin
                        y0_reg <= sy_reg ? y0_reg + COORD_W'(1) : y0_reg - COORD_W'(1);
                    end
                end
            end
            S_MARGIN:
            begin
                if (oy_reg == m_s)
                begin
                    oy_reg <= -m_s;
                    ox_reg <= ox_reg + 4'sd1;
                end
                else
                begin
                    oy_reg <= oy_reg + 4'sd1;
                end
            end
            S_RDATA:
            begin
                res_cell_reg <= rd_ok_reg ? mem_rd_data : CELL_UNKNOWN;
            end
            default:
            begin
            end
        endcase
    end

    lsog_grid_ram u_grid_ram
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lsog_div u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x),
        .den   (den_reg),
        .done  (div_x_done),
        .quo   (quo_x)
    );

    lsog_div u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y),
        .den   (den_reg),
        .done  (div_y_done),
        .quo   (quo_y)
    );

    `LSOG_ASSERT_IMP(a_dividers_in_step, div_x_done || div_y_done, div_x_done && div_y_done)
    `LSOG_ASSERT_IMP(a_no_write_when_ready, s_tready, !mem_wr.en)
    `LSOG_ASSERT_IMP(a_ray_drained_before_margin, state_reg == S_MARGIN, !pend_valid_reg)
    `LSOG_ASSERT_NXT(a_one_item_at_a_time, in_accept, !s_tready)

endmodule

/* sv/lsog_grid_ram.sv */
module lsog_grid_ram
    import lsog_pkg::*;
(
    input  logic              clk,
    input  grid_wr_t          wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [GRID_CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lsog_div.sv */
module lsog_div
    import lsog_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    input  logic        [DEN_W-1:0]  den,
    output logic                     done,
    output coord_t                   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    coord_t           quo_reg;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_next;

    assign shifted = {rem_reg, mag_reg[NUM_W-1]};
    assign ge = shifted >= {1'b0, den_reg};
    assign diff = shifted - {1'b0, den_reg};
    assign rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[NUM_W-2:0], ge};
        end
        if (run_reg && (cnt_reg == '0))
        begin
            quo_reg <= neg_reg ? COORD_W'(-mag_reg) : COORD_W'(mag_reg);
        end
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule
